// File: rtl/glu_pkg.sv
package glu_pkg;

    // default operand width
    localparam int OPERAND_WIDTH_DEF = 32;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } t_state;

    // shared adder operation
    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

endpackage

// File: rtl/gcd_lcm_unit.sv
// channel   direction  handshake             payload
// input     in         i_valid / o_ready     i_func, i_operand_a, i_operand_b
// result    out        o_valid / i_ready     o_answer
//
// gcd: binary (shift and subtract) euclid, one step per cycle on the shared adder,
//   so the length of the gcd phase is data dependent
// lcm: adds a shift-add multiply of the operands and a restoring divide by the gcd
// the done state then hands the result to the output register, and o_ready rises again
// o_ready is high only when idle; a waiting result stalls the next one only in its done state
// reset (synchronous, active low) clears the sequencer and the output valid only
module gcd_lcm_unit #(
    parameter int OPERAND_WIDTH = glu_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_func,
    input  logic [OPERAND_WIDTH-1:0] i_operand_a,
    input  logic [OPERAND_WIDTH-1:0] i_operand_b,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [OPERAND_WIDTH-1:0] o_answer
);
    import glu_pkg::*;

    localparam int W    = OPERAND_WIDTH;
    localparam int CNT_W = $clog2(W);

    // control
    t_state            r_state, n_state;
    logic              r_out_valid, n_out_valid;

    // datapath
    logic              r_func, n_func;
    logic [W-1:0]      r_a, n_a;
    logic [W-1:0]      r_b, n_b;
    logic [W-1:0]      r_x, n_x;      // gcd operand / multiplicand
    logic [W-1:0]      r_y, n_y;      // gcd operand / multiplier
    logic [CNT_W-1:0]  r_k, n_k;      // common power of two
    logic [W-1:0]      r_g, n_g;      // gcd
    logic [W-1:0]      r_p, n_p;      // product, then quotient
    logic [W-1:0]      r_rem, n_rem;  // divide remainder
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [W-1:0]      r_answer, n_answer;

    // shared adder
    t_alu_op           alu_op;
    logic [W:0]        alu_lhs;
    logic [W:0]        alu_rhs;
    logic [W:0]        alu_res;
    logic              alu_borrow;

    logic              in_xfer;
    logic              x_zero;
    logic              y_zero;

    glu_alu #(
        .OPERAND_WIDTH (W)
    ) u_alu (
        .i_op  (alu_op),
        .i_lhs (alu_lhs),
        .i_rhs (alu_rhs),
        .o_res (alu_res)
    );

    assign o_ready    = (r_state == ST_IDLE);
    assign o_valid    = r_out_valid;
    assign o_answer   = r_answer;
    assign in_xfer    = i_valid && o_ready;
    assign alu_borrow = alu_res[W];
    assign x_zero     = (r_x == '0);
    assign y_zero     = (r_y == '0);

    // adder operand select per phase
    always_comb begin
        case (r_state)
            ST_MUL: begin
                alu_op  = ALU_ADD;
                alu_lhs = {1'b0, r_p};
                alu_rhs = {1'b0, r_x};
            end
            ST_DIV: begin
                // shift next dividend bit into the remainder and trial subtract
                alu_op  = ALU_SUB;
                alu_lhs = {r_rem, r_p[W-1]};
                alu_rhs = {1'b0, r_g};
            end
            default: begin
                alu_op  = ALU_SUB;
                alu_lhs = {1'b0, r_x};
                alu_rhs = {1'b0, r_y};
            end
        endcase
    end

    // sequencer: next state and datapath
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_func      = r_func;
        n_a         = r_a;
        n_b         = r_b;
        n_x         = r_x;
        n_y         = r_y;
        n_k         = r_k;
        n_g         = r_g;
        n_p         = r_p;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_answer    = r_answer;

        // result taken downstream
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_func  = i_func;
                    n_a     = i_operand_a;
                    n_b     = i_operand_b;
                    n_x     = i_operand_a;
                    n_y     = i_operand_b;
                    n_k     = '0;
                    n_state = ST_GCD;
                end
            end
            ST_GCD: begin
                if (x_zero || y_zero) begin
                    // one side gone to zero: the other, rescaled, is the gcd
                    n_g = (x_zero ? r_y : r_x) << r_k;
                    if (!r_func || (x_zero && y_zero)) begin
                        // gcd wanted, or both operands zero giving lcm 0
                        n_p     = n_g;
                        n_state = ST_DONE;
                    end else begin
                        n_x     = r_a;
                        n_y     = r_b;
                        n_p     = '0;
                        n_cnt   = CNT_W'(W - 1);
                        n_state = ST_MUL;
                    end
                end else if (!r_x[0] && !r_y[0]) begin
                    n_x = r_x >> 1;
                    n_y = r_y >> 1;
                    n_k = r_k + CNT_W'(1);
                end else if (!r_x[0]) begin
                    n_x = r_x >> 1;
                end else if (!r_y[0]) begin
                    n_y = r_y >> 1;
                end else if (alu_borrow) begin
                    // both odd, x below y: swap so the next step subtracts
                    n_x = r_y;
                    n_y = r_x;
                end else begin
                    n_x = alu_res[W-1:0];
                end
            end
            ST_MUL: begin
                // shift-add, product wraps to the operand width
                if (r_y[0]) begin
                    n_p = alu_res[W-1:0];
                end
                n_x = r_x << 1;
                n_y = r_y >> 1;
                if (r_cnt == '0) begin
                    n_rem   = '0;
                    n_cnt   = CNT_W'(W - 1);
                    n_state = ST_DIV;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            ST_DIV: begin
                // restoring division, quotient bits shift into the product register
                if (!alu_borrow) begin
                    n_rem = alu_res[W-1:0];
                end else begin
                    n_rem = alu_lhs[W-1:0];
                end
                n_p = {r_p[W-2:0], ~alu_borrow};
                if (r_cnt == '0) begin
                    n_state = ST_DONE;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            ST_DONE: begin
                // hand over once the output register is free
                if (!r_out_valid || i_ready) begin
                    n_answer    = r_p;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_a      <= n_a;
        r_b      <= n_b;
        r_x      <= n_x;
        r_y      <= n_y;
        r_k      <= n_k;
        r_g      <= n_g;
        r_p      <= n_p;
        r_rem    <= n_rem;
        r_cnt    <= n_cnt;
        r_answer <= n_answer;
    end

    // a transfer always starts the gcd phase
    a_start_gcd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == ST_GCD))
        else $error("accepted item did not start gcd phase");

    // multiply and divide only run for lcm with a nonzero gcd
    a_lcm_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_MUL) || (r_state == ST_DIV)) |-> (r_func && (r_g != '0)))
        else $error("multiply or divide entered without lcm and nonzero gcd");

    // restoring divide keeps the remainder below the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < r_g))
        else $error("divide remainder not below divisor");

    // a finished result is only loaded into a free or draining output register
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DONE) && r_out_valid && !i_ready) |=> (r_state == ST_DONE))
        else $error("result left done state while output stalled");

endmodule

// File: rtl/glu_alu.sv
module glu_alu #(
    parameter int OPERAND_WIDTH = glu_pkg::OPERAND_WIDTH_DEF
) (
    input  glu_pkg::t_alu_op          i_op,
    input  logic [OPERAND_WIDTH:0]    i_lhs,
    input  logic [OPERAND_WIDTH:0]    i_rhs,
    output logic [OPERAND_WIDTH:0]    o_res
);
    import glu_pkg::*;

    // one adder, the top bit is the borrow in subtract mode
    always_comb begin
        case (i_op)
            ALU_ADD: o_res = i_lhs + i_rhs;
            ALU_SUB: o_res = i_lhs - i_rhs;
            default: o_res = i_lhs + i_rhs;
        endcase
    end

endmodule
